@@ sv/zrfd_pkg.sv @@
// Package for the zero-run frame deframer: result record, kind and register
// codes, default sizes and the CRC byte step. Used by the deframer and its testbench.
package zrfd_pkg;

  localparam int MAX_NODES_DEF      = 16;
  localparam int BROADCAST_NODE_DEF = 15;
  localparam int CAPACITY_MAX_DEF   = 4096;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_CRC_ERR   = 3'd2,
    KIND_OVERFLOW  = 3'd3,
    KIND_BAD_START = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_OWN_NODE    = 3'd0,
    REG_NODE_FILTER = 3'd1,
    REG_CAPACITY    = 3'd2,
    REG_CRC_POLY    = 3'd3,
    REG_CRC_REFLECT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] plen;
    logic [15:0] rcrc;
    logic [7:0]  lost;
    logic [7:0]  rep;
    logic [7:0]  value;
    logic [3:0]  node;
  } res_t;

  // One byte through the CRC register, msb first or reflected.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly, input logic refl);
    logic [15:0] c;
    c = refl ? (crc ^ {8'h00, b}) : (crc ^ {b, 8'h00});
    for (int k = 0; k < 8; k++) begin
      if (refl) begin
        c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end else begin
        c = c[15] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

@@ sv/zrfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module zrfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/zero_run_frame_deframer.sv @@
// Zero-run frame deframer: decodes byte-stuffed link frames into payload runs
// and per-frame verdicts. Uses zrfd_pkg and zrfd_ram.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one raw link byte per transfer.
//   m_tvalid/m_tready/m_tdata/m_tuser/m_tlast carry results: tuser is the
//   result kind, tlast marks the final result caused by one link byte.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the five setup registers;
//   cfg_ready is always high. Write them only while the block is idle.
// Timing:
//   One byte is handled at a time; s_tready is low while it is worked on.
//   A literal byte stores one decoded byte and a zero-run byte of count n stores n
//   zeros, then S_FLUSH; the shared CRC byte unit steps one decoded byte per cycle
//   unless a held payload result waits on a full output register.
//   A frame verdict reads the sequence table in S_VREAD, then emits in S_VERD.
// Reset: rst (synchronous) returns to idle, CRC to 0xFFFF, and marks every
//   sequence tracker as zero.
// Stall: results wait in one output register; when it is full and a new
//   result is due the sequencer holds until m_tready takes the old one.
module zero_run_frame_deframer #(
  parameter int MAX_NODES      = zrfd_pkg::MAX_NODES_DEF,
  parameter int BROADCAST_NODE = zrfd_pkg::BROADCAST_NODE_DEF,
  parameter int CAPACITY_MAX   = zrfd_pkg::CAPACITY_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_node[3:0], byte_value[11:4], repeat_count[19:12], lost_frames[27:20],
  // received_crc[43:28], payload_length[55:44]
  output logic [55:0] m_tdata,
  output logic [2:0]  m_tuser,   // kind[2:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [7:0]  BCAST8  = 8'(BROADCAST_NODE);
  localparam logic [8:0]  NODES9  = 9'(MAX_NODES);
  localparam logic [16:0] CAPMAX  = 17'(CAPACITY_MAX);

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH, S_FLUSH, S_VREAD, S_VERD, S_SINGLE
  } state_t;

  state_t state;

  // configuration
  logic [3:0]  own_node;
  logic        node_filter;
  logic [12:0] store_capacity;
  logic [15:0] crc_poly;
  logic        crc_reflect;

  // frame state
  logic        in_frame;
  logic [1:0]  zero_count;
  logic [3:0]  current_node;
  logic        overflowed;
  logic [12:0] decoded_size;
  logic [15:0] crc_running;
  logic [7:0]  tail0, tail1;
  logic [7:0]  first_byte;

  // work registers
  logic [7:0]  push_byte;
  logic [7:0]  remain;
  logic        pend_valid;
  logic [7:0]  pend_val;
  logic [7:0]  pend_cnt;
  zrfd_pkg::res_t single_res;
  logic [2:0]  single_kind;
  logic [AW-1:0] seq_addr;
  logic [MAX_NODES-1:0] seq_valid;
  logic        rd_valid;
  logic [7:0]  ram_q;

  zrfd_pkg::res_t out_res;

  logic        can_emit;
  logic [12:0] cap;
  logic [15:0] crc_in, crc_out;
  logic [7:0]  crc_b;
  logic        node_ok;
  logic [7:0]  node8;
  logic [7:0]  idx8;
  logic [7:0]  last_seq;
  logic [15:0] rcrc;
  logic        ram_we;
  logic        release_emit;

  assign can_emit  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tdata   = out_res;
  assign cap       = ({4'd0, store_capacity} > CAPMAX) ? CAPMAX[12:0] : store_capacity;
  assign node_ok   = !node_filter || (current_node == own_node) ||
                     ({4'd0, current_node} == BCAST8);
  assign node8     = 8'hFF - s_tdata;
  assign idx8      = (node_filter || ({5'd0, current_node} >= NODES9)) ? 8'd0
                     : {4'd0, current_node};
  assign last_seq  = rd_valid ? ram_q : 8'd0;
  assign rcrc      = {tail0, tail1};
  assign ram_we    = (state == S_VERD) && can_emit && (rcrc == crc_running);
  // a released byte that cannot merge pushes the pending run out
  assign release_emit = (decoded_size >= 13'd3) && pend_valid &&
                        !((pend_val == tail1) && (pend_cnt != 8'hFF));

  // shared CRC byte unit
  always_comb begin
    if (state == S_IDLE) begin
      crc_in = zrfd_pkg::CRC_INIT;
      crc_b  = s_tdata;
    end else begin
      crc_in = crc_running;
      crc_b  = tail1;
    end
    crc_out = zrfd_pkg::crc_byte(crc_in, crc_b, crc_poly, crc_reflect);
  end

  zrfd_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_seq_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seq_addr),
    .wdata (first_byte),
    .raddr (seq_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      own_node       <= '0;
      node_filter    <= 1'b0;
      store_capacity <= 13'd256;
      crc_poly       <= 16'h1021;
      crc_reflect    <= 1'b0;
      in_frame       <= 1'b0;
      zero_count     <= '0;
      current_node   <= '0;
      overflowed     <= 1'b0;
      decoded_size   <= '0;
      crc_running    <= zrfd_pkg::CRC_INIT;
      tail0          <= '0;
      tail1          <= '0;
      first_byte     <= '0;
      pend_valid     <= 1'b0;
      seq_valid      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          zrfd_pkg::REG_OWN_NODE:    own_node       <= cfg_data[3:0];
          zrfd_pkg::REG_NODE_FILTER: node_filter    <= cfg_data[0];
          zrfd_pkg::REG_CAPACITY:    store_capacity <= cfg_data[12:0];
          zrfd_pkg::REG_CRC_POLY:    crc_poly       <= cfg_data;
          zrfd_pkg::REG_CRC_REFLECT: crc_reflect    <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tdata != 8'd0) begin
              zero_count <= '0;
              if (overflowed) begin
                // drop until the break
              end else if (in_frame) begin
                if (node_ok) begin
                  push_byte  <= (zero_count != 2'd0) ? 8'd0 : s_tdata;
                  remain     <= (zero_count != 2'd0) ? s_tdata : 8'd1;
                  pend_valid <= 1'b0;
                  state      <= S_PUSH;
                end
              end else if ({1'b0, node8} < NODES9) begin
                in_frame     <= 1'b1;
                current_node <= node8[3:0];
                crc_running  <= crc_out;
                decoded_size <= '0;
                tail0        <= '0;
                tail1        <= '0;
                first_byte   <= '0;
              end else begin
                single_kind <= zrfd_pkg::KIND_BAD_START;
                single_res  <= '{plen: '0, rcrc: '0, lost: '0, rep: '0,
                                 value: s_tdata, node: '0};
                state       <= S_SINGLE;
              end
            end else begin
              if (zero_count != 2'd2) begin
                zero_count <= zero_count + 2'd1;
              end
              if (zero_count != 2'd0 && in_frame) begin
                in_frame   <= 1'b0;
                overflowed <= 1'b0;
                if (node_ok && overflowed) begin
                  decoded_size <= '0;
                  single_kind  <= zrfd_pkg::KIND_OVERFLOW;
                  single_res   <= '{plen: '0, rcrc: '0, lost: '0, rep: '0,
                                    value: '0, node: current_node};
                  state        <= S_SINGLE;
                end else if (node_ok && decoded_size >= 13'd3) begin
                  seq_addr <= idx8[AW-1:0];
                  state    <= S_VREAD;
                end else begin
                  decoded_size <= '0;
                end
              end
            end
          end
        end

        S_PUSH: begin
          if (decoded_size >= cap) begin
            overflowed <= 1'b1;
            state      <= S_FLUSH;
          end else if (!(release_emit && !can_emit)) begin
            if (decoded_size == 13'd0) begin
              first_byte <= push_byte;
            end
            if (decoded_size >= 13'd2) begin
              crc_running <= crc_out;
            end
            if (decoded_size >= 13'd3) begin
              if (release_emit) begin
                m_tvalid <= 1'b1;
                m_tuser  <= zrfd_pkg::KIND_PAYLOAD;
                m_tlast  <= 1'b0;
                out_res  <= '{plen: '0, rcrc: '0, lost: '0, rep: pend_cnt,
                              value: pend_val, node: current_node};
                pend_val <= tail1;
                pend_cnt <= 8'd1;
              end else if (pend_valid) begin
                pend_cnt <= pend_cnt + 8'd1;
              end else begin
                pend_valid <= 1'b1;
                pend_val   <= tail1;
                pend_cnt   <= 8'd1;
              end
            end
            tail1        <= tail0;
            tail0        <= push_byte;
            decoded_size <= decoded_size + 13'd1;
            remain       <= remain - 8'd1;
            if (remain == 8'd1) begin
              state <= S_FLUSH;
            end
          end
        end

        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (can_emit) begin
            m_tvalid   <= 1'b1;
            m_tuser    <= zrfd_pkg::KIND_PAYLOAD;
            m_tlast    <= 1'b1;
            out_res    <= '{plen: '0, rcrc: '0, lost: '0, rep: pend_cnt,
                            value: pend_val, node: current_node};
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        S_VREAD: begin
          rd_valid <= seq_valid[seq_addr];
          state    <= S_VERD;
        end

        S_VERD: begin
          if (can_emit) begin
            m_tvalid <= 1'b1;
            m_tlast  <= 1'b1;
            if (rcrc == crc_running) begin
              m_tuser <= zrfd_pkg::KIND_GOOD;
              out_res <= '{plen: 12'(decoded_size - 13'd3), rcrc: rcrc,
                           lost: first_byte - (last_seq + 8'd1), rep: '0,
                           value: first_byte, node: current_node};
              seq_valid[seq_addr] <= 1'b1;
            end else begin
              m_tuser <= zrfd_pkg::KIND_CRC_ERR;
              out_res <= '{plen: 12'(decoded_size - 13'd3), rcrc: rcrc,
                           lost: '0, rep: '0, value: '0, node: current_node};
            end
            decoded_size <= '0;
            state        <= S_IDLE;
          end
        end

        S_SINGLE: begin
          if (can_emit) begin
            m_tvalid <= 1'b1;
            m_tlast  <= 1'b1;
            m_tuser  <= single_kind;
            out_res  <= single_res;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_zero_run_frame_deframer.sv @@
// Testbench for zero_run_frame_deframer: builds stuffed frames and link noise,
// predicts payload runs and frame verdicts, and checks every result transfer.
// Depends on zrfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_zero_run_frame_deframer;

  typedef logic [7:0] bytes_t[$];

  typedef struct {
    zrfd_pkg::kind_t kind;
    logic [3:0]  node;
    logic [7:0]  value;
    logic [7:0]  rep;
    logic [7:0]  lost;
    logic [15:0] rcrc;
    logic [11:0] plen;
    logic        last;
  } verdict_t;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'h0000;

  zero_run_frame_deframer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow registers and decoder state.
  logic [3:0]  own_r;
  logic        filt_r;
  logic [12:0] cap_r;
  logic [15:0] poly_r;
  logic        refl_r;
  logic        in_frame, ovf;
  logic [1:0]  zeros_seen;
  logic [3:0]  cur_node;
  logic [12:0] dec_size;
  logic [15:0] crc_acc;
  logic [7:0]  tail0, tail1, seq_byte;
  logic [7:0]  seq_hist[16];

  verdict_t    pend[3];
  int          pend_n;
  verdict_t    expected_q[$];

  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_frames = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int stall_left = 0;

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    if (refl_r) begin
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ poly_r) : (c >> 1);
    end else begin
      c = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ poly_r) : (c << 1);
    end
    return c;
  endfunction

  task automatic add_result(input zrfd_pkg::kind_t k, input logic [3:0] nd,
                            input logic [7:0] v, input logic [7:0] rp, input logic [7:0] ls,
                            input logic [15:0] rc, input logic [11:0] pl);
    if (pend_n < 3) begin
      pend[pend_n] = '{k, nd, v, rp, ls, rc, pl, 1'b0};
      pend_n++;
    end
  endtask

  task automatic add_payload(input logic [7:0] v);
    if (pend_n > 0 && pend[pend_n-1].kind == zrfd_pkg::KIND_PAYLOAD &&
        pend[pend_n-1].value == v && pend[pend_n-1].rep < 8'd255) begin
      pend[pend_n-1].rep++;
    end else begin
      add_result(zrfd_pkg::KIND_PAYLOAD, cur_node, v, 8'd1, 8'd0, 16'd0, 12'd0);
    end
  endtask

  task automatic store_byte(input logic [7:0] b);
    logic [12:0] cap;
    cap = (cap_r > 13'(zrfd_pkg::CAPACITY_MAX_DEF)) ? 13'(zrfd_pkg::CAPACITY_MAX_DEF)
                                                    : cap_r;
    if (dec_size >= cap) begin
      ovf = 1'b1;
    end else begin
      if (dec_size == 0) seq_byte = b;
      if (dec_size >= 2) begin
        crc_acc = crc_next(crc_acc, tail1);
        if (dec_size >= 3) add_payload(tail1);
      end
      tail1 = tail0;
      tail0 = b;
      dec_size++;
    end
  endtask

  task automatic frame_verdict();
    logic [15:0] rc;
    logic [3:0]  idx;
    if (ovf) begin
      add_result(zrfd_pkg::KIND_OVERFLOW, cur_node, 8'd0, 8'd0, 8'd0, 16'd0, 12'd0);
    end else if (dec_size >= 3) begin
      rc = {tail0, tail1};
      if (rc == crc_acc) begin
        idx = filt_r ? 4'd0 : cur_node;
        add_result(zrfd_pkg::KIND_GOOD, cur_node, seq_byte, 8'd0,
                   seq_byte - (seq_hist[idx] + 8'd1), rc, 12'(dec_size - 13'd3));
        seq_hist[idx] = seq_byte;
      end else begin
        add_result(zrfd_pkg::KIND_CRC_ERR, cur_node, 8'd0, 8'd0, 8'd0, rc,
                   12'(dec_size - 13'd3));
      end
    end
  endtask

  // Work out the results that one accepted link byte causes.
  task automatic predict_byte(input logic [7:0] c);
    logic [7:0] nd;
    bit         acc;
    pend_n = 0;
    acc = !filt_r || cur_node == own_r || cur_node == 4'(zrfd_pkg::BROADCAST_NODE_DEF);
    if (c != 0) begin
      if (ovf) begin
        // drop the rest of the frame
      end else if (in_frame) begin
        if (acc) begin
          if (zeros_seen != 0) begin
            for (int k = 0; k < c && !ovf; k++) store_byte(8'h00);
          end else begin
            store_byte(c);
          end
        end
      end else begin
        nd = 8'hFF - c;
        if (nd < zrfd_pkg::MAX_NODES_DEF) begin
          in_frame = 1'b1;
          cur_node = nd[3:0];
          crc_acc  = crc_next(zrfd_pkg::CRC_INIT, c);
          dec_size = 0;
          tail0 = 0;
          tail1 = 0;
          seq_byte = 0;
        end else begin
          add_result(zrfd_pkg::KIND_BAD_START, 4'd0, c, 8'd0, 8'd0, 16'd0, 12'd0);
        end
      end
      zeros_seen = 0;
    end else begin
      if (zeros_seen < 2) zeros_seen++;
      if (zeros_seen > 1 && in_frame) begin
        if (acc) frame_verdict();
        in_frame = 1'b0;
        ovf = 1'b0;
        dec_size = 0;
      end
    end
    if (pend_n > 0) pend[pend_n-1].last = 1'b1;
    for (int i = 0; i < pend_n; i++) expected_q.push_back(pend[i]);
  endtask

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_result();
    verdict_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result kind %0d data %h", m_tuser, m_tdata));
    end else begin
      e = expected_q.pop_front();
      n_results++;
      if (m_tuser != e.kind) report($sformatf("kind %0d, want %0d", m_tuser, e.kind));
      if (m_tdata[3:0] != e.node) report($sformatf("node %0d, want %0d", m_tdata[3:0], e.node));
      if (m_tdata[11:4] != e.value)
        report($sformatf("value %h, want %h", m_tdata[11:4], e.value));
      if (m_tdata[19:12] != e.rep) report($sformatf("repeat %0d, want %0d", m_tdata[19:12], e.rep));
      if (m_tdata[27:20] != e.lost) report($sformatf("lost %0d, want %0d", m_tdata[27:20], e.lost));
      if (m_tdata[43:28] != e.rcrc) report($sformatf("crc %h, want %h", m_tdata[43:28], e.rcrc));
      if (m_tdata[55:44] != e.plen)
        report($sformatf("length %0d, want %0d", m_tdata[55:44], e.plen));
      if (m_tlast != e.last) report($sformatf("tlast %0d, want %0d", m_tlast, e.last));
    end
  endtask

  // Long receiver hold, counted in cycles.
  always @(posedge clk) begin
    if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= 600;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side: check each transfer, then pick next tready.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
    if (hold_left > 0) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    predict_byte(b);
    n_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Stuff and send one frame; cut > 0 breaks it off after that many link bytes.
  task automatic send_frame(input logic [3:0] node, input logic [7:0] seq, input bytes_t pl,
                            input bit bad_crc, input int cut);
    bytes_t dec, enc;
    logic [15:0] crc;
    logic [7:0]  st;
    int i, n;
    st = 8'hFF - 8'(node);
    crc = crc_next(zrfd_pkg::CRC_INIT, st);
    dec.push_back(seq);
    foreach (pl[j]) dec.push_back(pl[j]);
    foreach (dec[j]) crc = crc_next(crc, dec[j]);
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    dec.push_back(crc[7:0]);
    dec.push_back(crc[15:8]);
    enc.push_back(st);
    i = 0;
    while (i < dec.size()) begin
      if (dec[i] != 0) begin
        enc.push_back(dec[i]);
        i++;
      end else begin
        n = 0;
        while (i < dec.size() && dec[i] == 0 && n < 255) begin
          n++;
          i++;
        end
        enc.push_back(8'h00);
        enc.push_back(8'(n));
      end
    end
    if (cut > 0 && cut < enc.size()) enc = enc[0:cut-1];
    foreach (enc[j]) send_byte(enc[j]);
    send_byte(8'h00);
    send_byte(8'h00);
    n_frames++;
  endtask

  // Quiet the input and let every due result come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input zrfd_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      zrfd_pkg::REG_OWN_NODE:    own_r  = val[3:0];
      zrfd_pkg::REG_NODE_FILTER: filt_r = val[0];
      zrfd_pkg::REG_CAPACITY:    cap_r  = val[12:0];
      zrfd_pkg::REG_CRC_POLY:    poly_r = val;
      zrfd_pkg::REG_CRC_REFLECT: refl_r = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(input logic [3:0] own, input bit filt, input logic [12:0] cap,
                       input logic [15:0] poly, input bit refl);
    drain();
    write_reg(zrfd_pkg::REG_OWN_NODE, 16'(own));
    write_reg(zrfd_pkg::REG_NODE_FILTER, 16'(filt));
    write_reg(zrfd_pkg::REG_CAPACITY, 16'(cap));
    write_reg(zrfd_pkg::REG_CRC_POLY, poly);
    write_reg(zrfd_pkg::REG_CRC_REFLECT, 16'(refl));
  endtask

  function automatic bytes_t rand_payload(input int len);
    bytes_t p;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0, 1: p.push_back(8'h00);
        2: p.push_back(8'hFF);
        default: p.push_back(8'($urandom));
      endcase
    end
    return p;
  endfunction

  task automatic test_directed();
    bytes_t p;
    send_byte(8'h01);          // bad start, node 254 out of range
    send_byte(8'hEF);          // bad start just past node 15
    send_byte(8'h00);          // idle zeros
    send_byte(8'h00);
    send_byte(8'h00);
    p = {8'hFF, 8'h00, 8'h80, 8'h80};
    send_frame(4'd0, 8'h00, p, 1'b0, 0);
    p = {};
    for (int i = 0; i < 255; i++) p.push_back(8'h00);
    send_frame(4'd15, 8'hFF, p, 1'b0, 0);
    send_byte(8'h00);          // extra zero after a break
    p = {8'h01};
    send_frame(4'd3, 8'h10, p, 1'b1, 0);
    p = {8'h55};
    send_frame(4'd4, 8'h22, p, 1'b0, 3);   // short frame
  endtask

  task automatic test_config_extremes();
    setup(4'd0, 1'b0, 13'd4096, 16'h0000, 1'b0);
    send_frame(4'd1, 8'h01, rand_payload(4), 1'b0, 0);
    setup(4'd15, 1'b0, 13'd4096, 16'hFFFF, 1'b1);
    send_frame(4'd2, 8'h07, rand_payload(4), 1'b0, 0);
    setup(4'd9, 1'b0, 13'd256, 16'hA001, 1'b1);
    send_frame(4'd9, 8'h33, rand_payload(6), 1'b0, 0);
  endtask

  task automatic test_filter();
    setup(4'd6, 1'b1, 13'd256, 16'h1021, 1'b0);
    send_frame(4'd6, 8'h05, rand_payload(3), 1'b0, 0);
    send_frame(4'd15, 8'h09, rand_payload(3), 1'b0, 0);
    send_frame(4'd2, 8'h0A, rand_payload(3), 1'b0, 0);
    send_frame(4'd6, 8'h0B, rand_payload(2), 1'b1, 0);
  endtask

  task automatic test_overflow();
    bytes_t p;
    setup(4'd0, 1'b0, 13'd33, 16'h8005, 1'b0);
    send_frame(4'd5, 8'h01, rand_payload(30), 1'b0, 0);   // exactly at capacity
    send_frame(4'd5, 8'h02, rand_payload(31), 1'b0, 0);
    p = {};
    for (int i = 0; i < 60; i++) p.push_back(8'h00);
    send_frame(4'd7, 8'h03, p, 1'b0, 0);
  endtask

  task automatic test_backpressure();
    setup(4'd0, 1'b0, 13'd256, 16'h1021, 1'b0);
    hold_req <= hold_req + 1;
    for (int i = 0; i < 4; i++) send_frame(4'(i), 8'(i), rand_payload(6), 1'b0, 0);
  endtask

  task automatic test_random(input int target);
    bytes_t p;
    int len, pick, cnt;
    while (n_sent < target) begin
      if ($urandom_range(0, 15) == 0) begin
        setup(4'($urandom), 1'($urandom_range(0, 1)),
              ($urandom_range(0, 3) == 0) ? 13'($urandom_range(33, 4096))
                                          : 13'($urandom_range(33, 48)),
              16'($urandom), 1'($urandom_range(0, 1)));
      end
      len = $urandom_range(0, 12);
      p = rand_payload(len);
      if ($urandom_range(0, 19) == 0) begin
        cnt = $urandom_range(40, 255);
        for (int i = 0; i < cnt; i++) p.push_back(8'h00);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_frame(4'($urandom), 8'($urandom), p, 1'b0, 0);
      end else if (pick == 6) begin
        send_frame(4'($urandom), 8'($urandom), p, 1'b1, 0);
      end else if (pick == 7) begin
        send_frame(4'($urandom), 8'($urandom), p, 1'b0, $urandom_range(1, 4));
      end else begin
        cnt = $urandom_range(1, 3);
        for (int i = 0; i < cnt; i++) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    own_r = 0; filt_r = 0; cap_r = 13'd256; poly_r = 16'h1021; refl_r = 0;
    in_frame = 0; ovf = 0; zeros_seen = 0; cur_node = 0; dec_size = 0;
    crc_acc = zrfd_pkg::CRC_INIT; tail0 = 0; tail1 = 0; seq_byte = 0;
    foreach (seq_hist[i]) seq_hist[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_filter();
    test_overflow();
    test_backpressure();
    test_random(n_sent + 20);
    drain();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    test_random(n_sent + 15);
    drain();
    $display("covered %0d link bytes in %0d frames, %0d results checked", n_sent, n_frames,
             n_results);
    $display("filtering, overflow, crc variants and output backpressure exercised");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
